/* sv/ising_metropolis_spin_update_assert.svh */
// Assertion macros shared by the spin update modules.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_ASSERT_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_ASSERT_SVH

// Check cons in the same cycle as ante; clock clk, reset rst_n.
`define ISINGMP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante; clock clk, reset rst_n.
`define ISINGMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/isingmp_pkg.sv */
// Shared constants and types of the Ising spin update block.
package isingmp_pkg;

  localparam int SIDE_DEFAULT  = 64;
  localparam int INDEX_IN_W    = 6;
  localparam int FRAC_W        = 32;
  localparam int DE_W          = 5;
  localparam int ENERGY_OUT_W  = 15;
  localparam int MAG_OUT_W     = 14;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_PAYLOAD_W = 1 + DE_W + ENERGY_OUT_W + MAG_OUT_W;
  localparam int OUT_TDATA_W   = 40;
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 32;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_TRIAL = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEPT_FOUR  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEPT_EIGHT = 1'd1;

  // Back part to front part: pop the queue head, lattice ready for requests.
  typedef struct packed {
    logic pop;
    logic run;
  } back_ctrl_t;

endpackage

/* sv/isingmp_ram.sv */
// Generic RAM: one write port, two registered read ports.
module isingmp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

/* sv/isingmp_front.sv */
// Front part: accept requests, wrap site indices, queue them for the back part.
module isingmp_front #(
  parameter int SIDE = isingmp_pkg::SIDE_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [isingmp_pkg::INDEX_IN_W-1:0]   in_row,
  input  logic [isingmp_pkg::INDEX_IN_W-1:0]   in_col,
  input  logic                                 in_spin_up,
  input  logic [isingmp_pkg::FRAC_W-1:0]       in_frac,
  input  isingmp_pkg::back_ctrl_t              ctrl,
  output logic                                 q_valid,
  output logic                                 q_kind,
  output logic [$clog2(SIDE)-1:0]              q_row,
  output logic [$clog2(SIDE)-1:0]              q_row_up,
  output logic [$clog2(SIDE)-1:0]              q_row_dn,
  output logic [$clog2(SIDE)-1:0]              q_col,
  output logic [$clog2(SIDE)-1:0]              q_col_l,
  output logic [$clog2(SIDE)-1:0]              q_col_r,
  output logic                                 q_spin_up,
  output logic [isingmp_pkg::FRAC_W-1:0]       q_frac
);

  localparam int IW       = $clog2(SIDE);
  localparam int IN_RANGE = 1 << isingmp_pkg::INDEX_IN_W;
  localparam int DEPTH    = 2;
  localparam int PW       = 1;
  localparam int CW       = 2;

  logic [IW-1:0] mod_lut [IN_RANGE];
  logic [IW-1:0] row, row_up, row_dn, col, col_l, col_r;
  logic          push, pop;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;

  logic                           kind_mem_r   [DEPTH];
  logic [IW-1:0]                  row_mem_r    [DEPTH];
  logic [IW-1:0]                  row_up_mem_r [DEPTH];
  logic [IW-1:0]                  row_dn_mem_r [DEPTH];
  logic [IW-1:0]                  col_mem_r    [DEPTH];
  logic [IW-1:0]                  col_l_mem_r  [DEPTH];
  logic [IW-1:0]                  col_r_mem_r  [DEPTH];
  logic                           spin_mem_r   [DEPTH];
  logic [isingmp_pkg::FRAC_W-1:0] frac_mem_r   [DEPTH];

  // Index modulo SIDE as a constant table over all field codes.
  for (genvar g = 0; g < IN_RANGE; g++) begin : g_mod
    assign mod_lut[g] = IW'(g % SIDE);
  end

  always_comb begin
    row    = mod_lut[in_row];
    col    = mod_lut[in_col];
    row_up = (row == '0) ? IW'(SIDE - 1) : row - IW'(1);
    row_dn = (row == IW'(SIDE - 1)) ? '0 : row + IW'(1);
    col_l  = (col == '0) ? IW'(SIDE - 1) : col - IW'(1);
    col_r  = (col == IW'(SIDE - 1)) ? '0 : col + IW'(1);
  end

  assign in_ready = ctrl.run && (cnt_r != CW'(DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = ctrl.pop;

  always_comb begin
    cnt_nxt    = cnt_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind_mem_r[wr_ptr_r]   <= in_kind;
      row_mem_r[wr_ptr_r]    <= row;
      row_up_mem_r[wr_ptr_r] <= row_up;
      row_dn_mem_r[wr_ptr_r] <= row_dn;
      col_mem_r[wr_ptr_r]    <= col;
      col_l_mem_r[wr_ptr_r]  <= col_l;
      col_r_mem_r[wr_ptr_r]  <= col_r;
      spin_mem_r[wr_ptr_r]   <= in_spin_up;
      frac_mem_r[wr_ptr_r]   <= in_frac;
    end
  end

  assign q_valid   = (cnt_r != '0);
  assign q_kind    = kind_mem_r[rd_ptr_r];
  assign q_row     = row_mem_r[rd_ptr_r];
  assign q_row_up  = row_up_mem_r[rd_ptr_r];
  assign q_row_dn  = row_dn_mem_r[rd_ptr_r];
  assign q_col     = col_mem_r[rd_ptr_r];
  assign q_col_l   = col_l_mem_r[rd_ptr_r];
  assign q_col_r   = col_r_mem_r[rd_ptr_r];
  assign q_spin_up = spin_mem_r[rd_ptr_r];
  assign q_frac    = frac_mem_r[rd_ptr_r];

`include "ising_metropolis_spin_update_assert.svh"

  `ISINGMP_ASSERT_SAME(a_pop_not_empty, pop, cnt_r != '0, "pop from empty queue")
  `ISINGMP_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "queue count overrun")

endmodule

/* sv/isingmp_back.sv */
// Back part: clear the lattice, run trials and loads, keep totals, hold the result.
module isingmp_back #(
  parameter int SIDE = isingmp_pkg::SIDE_DEFAULT
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         cfg_we,
  input  logic [isingmp_pkg::CFG_ADDR_W-1:0]           cfg_addr,
  input  logic [isingmp_pkg::CFG_DATA_W-1:0]           cfg_wdata,
  input  logic                                         q_valid,
  input  logic                                         q_kind,
  input  logic [$clog2(SIDE)-1:0]                      q_row,
  input  logic [$clog2(SIDE)-1:0]                      q_row_up,
  input  logic [$clog2(SIDE)-1:0]                      q_row_dn,
  input  logic [$clog2(SIDE)-1:0]                      q_col,
  input  logic [$clog2(SIDE)-1:0]                      q_col_l,
  input  logic [$clog2(SIDE)-1:0]                      q_col_r,
  input  logic                                         q_spin_up,
  input  logic [isingmp_pkg::FRAC_W-1:0]               q_frac,
  output isingmp_pkg::back_ctrl_t                      ctrl,
  output logic                                         ram_we,
  output logic [$clog2(SIDE)-1:0]                      ram_waddr,
  output logic [SIDE-1:0]                              ram_wdata,
  output logic [$clog2(SIDE)-1:0]                      ram_raddr_a,
  input  logic [SIDE-1:0]                              ram_rdata_a,
  output logic [$clog2(SIDE)-1:0]                      ram_raddr_b,
  input  logic [SIDE-1:0]                              ram_rdata_b,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic                                         out_accepted,
  output logic signed [isingmp_pkg::DE_W-1:0]         out_delta_energy,
  output logic signed [isingmp_pkg::ENERGY_OUT_W-1:0] out_energy_total,
  output logic signed [isingmp_pkg::MAG_OUT_W-1:0]    out_magnetization_total
);

  localparam int IW     = $clog2(SIDE);
  localparam int SITES  = SIDE * SIDE;
  localparam int DW     = isingmp_pkg::DE_W;
  localparam int FW     = isingmp_pkg::FRAC_W;
  localparam int E_NEED = $clog2(2 * SITES) + 2;
  localparam int E_W    = (E_NEED > isingmp_pkg::ENERGY_OUT_W) ? E_NEED
                                                              : isingmp_pkg::ENERGY_OUT_W;
  localparam int M_NEED = $clog2(SITES) + 2;
  localparam int M_W    = (M_NEED > isingmp_pkg::MAG_OUT_W) ? M_NEED : isingmp_pkg::MAG_OUT_W;
  localparam logic signed [E_W-1:0] E_RESET = E_W'(-2 * SITES);
  localparam logic signed [M_W-1:0] M_RESET = M_W'(SITES);
  localparam logic signed [DW-1:0]  DE_FOUR = DW'(4);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ2,
    ST_EVAL
  } state_t;

  state_t state_r, state_nxt;

  logic [IW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [FW-1:0]   lvl4_r, lvl4_nxt;
  logic [FW-1:0]   lvl8_r, lvl8_nxt;

  logic            cur_kind_r, cur_kind_nxt;
  logic [IW-1:0]   cur_row_r, cur_row_nxt;
  logic [IW-1:0]   cur_row_up_r, cur_row_up_nxt;
  logic [IW-1:0]   cur_col_r, cur_col_nxt;
  logic [IW-1:0]   cur_col_l_r, cur_col_l_nxt;
  logic [IW-1:0]   cur_col_r_r, cur_col_r_nxt;
  logic            cur_spin_r, cur_spin_nxt;
  logic [FW-1:0]   cur_frac_r, cur_frac_nxt;
  logic [SIDE-1:0] row_w_r, row_w_nxt;
  logic [SIDE-1:0] dn_w_r, dn_w_nxt;

  logic signed [E_W-1:0] energy_r, energy_nxt;
  logic signed [M_W-1:0] mag_r, mag_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_acc_r, out_acc_nxt;
  logic signed [DW-1:0]    out_de_r, out_de_nxt;
  logic signed [isingmp_pkg::ENERGY_OUT_W-1:0] out_energy_r, out_energy_nxt;
  logic signed [isingmp_pkg::MAG_OUT_W-1:0]    out_mag_r, out_mag_nxt;

  logic                 s_bit, nb_l, nb_r, nb_u, nb_d;
  logic [2:0]           ones;
  logic [DW:0]          de_raw;
  logic signed [DW-1:0] de_flip;
  logic                 trial_take, do_flip, acc, eval_fire, start;
  logic signed [DW-1:0] de_out;

  // Neighbour sum and energy change of flipping the current site.
  always_comb begin
    s_bit   = row_w_r[cur_col_r];
    nb_l    = row_w_r[cur_col_l_r];
    nb_r    = row_w_r[cur_col_r_r];
    nb_u    = ram_rdata_a[cur_col_r];
    nb_d    = dn_w_r[cur_col_r];
    ones    = 3'(nb_l) + 3'(nb_r) + 3'(nb_u) + 3'(nb_d);
    // 2 * s * (2 * ones - 4): for an up spin that is 4 * ones - 8.
    de_raw  = {1'b0, ones, 2'b00} - (DW + 1)'(8);
    de_flip = s_bit ? $signed(de_raw[DW-1:0]) : -$signed(de_raw[DW-1:0]);

    if (de_flip[DW-1] || (de_flip == '0)) begin
      trial_take = 1'b1;
    end else if (de_flip == DE_FOUR) begin
      trial_take = (cur_frac_r <= lvl4_r);
    end else begin
      trial_take = (cur_frac_r <= lvl8_r);
    end

    // A load that changes the spin is the same flip as an accepted trial.
    if (cur_kind_r == isingmp_pkg::KIND_TRIAL) begin
      do_flip = trial_take;
      acc     = trial_take;
      de_out  = de_flip;
    end else begin
      do_flip = (cur_spin_r != s_bit);
      acc     = 1'b1;
      de_out  = do_flip ? de_flip : '0;
    end
  end

  assign eval_fire = (state_r == ST_EVAL) && (!out_valid_r || out_ready);
  assign start     = (state_r == ST_IDLE) && q_valid;

  assign ctrl.pop = start;
  assign ctrl.run = (state_r != ST_CLEAR);

  // Row memory ports: center and lower row first, upper row held through evaluation.
  always_comb begin
    ram_raddr_a = (state_r == ST_IDLE) ? q_row : cur_row_up_r;
    ram_raddr_b = q_row_dn;
    ram_we      = 1'b0;
    ram_waddr   = cur_row_r;
    ram_wdata   = row_w_r ^ (SIDE'(1) << cur_col_r);
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '1;
    end else if (eval_fire && do_flip) begin
      ram_we    = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    lvl4_nxt       = lvl4_r;
    lvl8_nxt       = lvl8_r;
    cur_kind_nxt   = cur_kind_r;
    cur_row_nxt    = cur_row_r;
    cur_row_up_nxt = cur_row_up_r;
    cur_col_nxt    = cur_col_r;
    cur_col_l_nxt  = cur_col_l_r;
    cur_col_r_nxt  = cur_col_r_r;
    cur_spin_nxt   = cur_spin_r;
    cur_frac_nxt   = cur_frac_r;
    row_w_nxt      = row_w_r;
    dn_w_nxt       = dn_w_r;
    energy_nxt     = energy_r;
    mag_nxt        = mag_r;
    out_valid_nxt  = out_valid_r;
    out_acc_nxt    = out_acc_r;
    out_de_nxt     = out_de_r;
    out_energy_nxt = out_energy_r;
    out_mag_nxt    = out_mag_r;

    if (cfg_we) begin
      unique case (cfg_addr)
        isingmp_pkg::CFG_ACCEPT_FOUR:  lvl4_nxt = cfg_wdata;
        isingmp_pkg::CFG_ACCEPT_EIGHT: lvl8_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == IW'(SIDE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cur_kind_nxt   = q_kind;
          cur_row_nxt    = q_row;
          cur_row_up_nxt = q_row_up;
          cur_col_nxt    = q_col;
          cur_col_l_nxt  = q_col_l;
          cur_col_r_nxt  = q_col_r;
          cur_spin_nxt   = q_spin_up;
          cur_frac_nxt   = q_frac;
          state_nxt      = ST_READ2;
        end
      end
      ST_READ2: begin
        row_w_nxt = ram_rdata_a;
        dn_w_nxt  = ram_rdata_b;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (eval_fire) begin
          if (do_flip) begin
            energy_nxt = energy_r + {{(E_W - DW){de_flip[DW-1]}}, de_flip};
            mag_nxt    = s_bit ? mag_r - M_W'(2) : mag_r + M_W'(2);
          end
          out_valid_nxt  = 1'b1;
          out_acc_nxt    = acc;
          out_de_nxt     = de_out;
          out_energy_nxt = energy_nxt[isingmp_pkg::ENERGY_OUT_W-1:0];
          out_mag_nxt    = mag_nxt[isingmp_pkg::MAG_OUT_W-1:0];
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      lvl4_r      <= '0;
      lvl8_r      <= '0;
      energy_r    <= E_RESET;
      mag_r       <= M_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      lvl4_r      <= lvl4_nxt;
      lvl8_r      <= lvl8_nxt;
      energy_r    <= energy_nxt;
      mag_r       <= mag_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_kind_r   <= cur_kind_nxt;
    cur_row_r    <= cur_row_nxt;
    cur_row_up_r <= cur_row_up_nxt;
    cur_col_r    <= cur_col_nxt;
    cur_col_l_r  <= cur_col_l_nxt;
    cur_col_r_r  <= cur_col_r_nxt;
    cur_spin_r   <= cur_spin_nxt;
    cur_frac_r   <= cur_frac_nxt;
    row_w_r      <= row_w_nxt;
    dn_w_r       <= dn_w_nxt;
    out_acc_r    <= out_acc_nxt;
    out_de_r     <= out_de_nxt;
    out_energy_r <= out_energy_nxt;
    out_mag_r    <= out_mag_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_accepted            = out_acc_r;
  assign out_delta_energy        = out_de_r;
  assign out_energy_total        = out_energy_r;
  assign out_magnetization_total = out_mag_r;

`include "ising_metropolis_spin_update_assert.svh"

  `ISINGMP_ASSERT_SAME(a_we_phase, ram_we, (state_r == ST_CLEAR) || (state_r == ST_EVAL),
    "row write outside clear or evaluate step")
  `ISINGMP_ASSERT_NEXT(a_fire_loads_out, eval_fire, out_valid_r,
    "evaluated request left no result")
  `ISINGMP_ASSERT_NEXT(a_mag_only_on_flip, !(eval_fire && do_flip), $stable(mag_r),
    "magnetization moved without a flip")

endmodule

/* sv/ising_metropolis_spin_update.sv */
// Top level of the 2D Ising Metropolis spin update block.
//
// Input channel (in_*): one request per handshake. in_tuser is the kind: load one spin
// or run one Metropolis trial at the site given by row and column (wrapped modulo SIDE).
// Output channel (out_*): exactly one result per request, in request order: accepted
// flag, energy change, and energy and magnetization totals after the request.
// Configuration (cfg_*): write the two acceptance levels, only while the block is idle.
// The lattice lives in a row-wide memory, SIDE rows of SIDE bits, two read ports and one
// write port. In the back part each request passes these steps in order: read the center and
// lower rows, read the upper row, then evaluate and write the center row back. The back
// part takes no new request until the evaluate step is done; out_tvalid is set by a register
// loaded in that step.
// A two-entry queue sits between the front and back parts, so requests keep flowing in
// while a result waits in the output register.
// After reset the back part sweeps the lattice to all spins up, one row per cycle, through
// all SIDE rows; in_tready stays low during that sweep.
// When the receiver stalls, hold the result; the back part waits in its evaluate step
// and the queue fills, then in_tready drops.
module ising_metropolis_spin_update #(
  parameter int SIDE = isingmp_pkg::SIDE_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: row_index[5:0], col_index[11:6], spin_up[12], random_fraction[44:13], 0
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [isingmp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: kind[0]
  input  logic                                  in_tuser,
  // out_tdata: accepted[0], delta_energy[5:1], energy_total[20:6],
  //            magnetization_total[34:21], 0
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [isingmp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                                  cfg_we,
  input  logic [isingmp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [isingmp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int IW = $clog2(SIDE);

  isingmp_pkg::back_ctrl_t ctrl;

  logic                                        q_valid, q_kind, q_spin_up;
  logic [IW-1:0]                               q_row, q_row_up, q_row_dn;
  logic [IW-1:0]                               q_col, q_col_l, q_col_r;
  logic [isingmp_pkg::FRAC_W-1:0]              q_frac;

  logic                                        ram_we;
  logic [IW-1:0]                               ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [SIDE-1:0]                             ram_wdata, ram_rdata_a, ram_rdata_b;

  logic                                        res_acc;
  logic signed [isingmp_pkg::DE_W-1:0]         res_de;
  logic signed [isingmp_pkg::ENERGY_OUT_W-1:0] res_energy;
  logic signed [isingmp_pkg::MAG_OUT_W-1:0]    res_mag;

  // Accept, wrap indices and queue.
  isingmp_front #(
    .SIDE (SIDE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_row     (in_tdata[5:0]),
    .in_col     (in_tdata[11:6]),
    .in_spin_up (in_tdata[12]),
    .in_frac    (in_tdata[44:13]),
    .ctrl       (ctrl),
    .q_valid    (q_valid),
    .q_kind     (q_kind),
    .q_row      (q_row),
    .q_row_up   (q_row_up),
    .q_row_dn   (q_row_dn),
    .q_col      (q_col),
    .q_col_l    (q_col_l),
    .q_col_r    (q_col_r),
    .q_spin_up  (q_spin_up),
    .q_frac     (q_frac)
  );

  // Evaluate against the lattice and keep the totals.
  isingmp_back #(
    .SIDE (SIDE)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_addr                (cfg_addr),
    .cfg_wdata               (cfg_wdata),
    .q_valid                 (q_valid),
    .q_kind                  (q_kind),
    .q_row                   (q_row),
    .q_row_up                (q_row_up),
    .q_row_dn                (q_row_dn),
    .q_col                   (q_col),
    .q_col_l                 (q_col_l),
    .q_col_r                 (q_col_r),
    .q_spin_up               (q_spin_up),
    .q_frac                  (q_frac),
    .ctrl                    (ctrl),
    .ram_we                  (ram_we),
    .ram_waddr               (ram_waddr),
    .ram_wdata               (ram_wdata),
    .ram_raddr_a             (ram_raddr_a),
    .ram_rdata_a             (ram_rdata_a),
    .ram_raddr_b             (ram_raddr_b),
    .ram_rdata_b             (ram_rdata_b),
    .out_valid               (out_tvalid),
    .out_ready               (out_tready),
    .out_accepted            (res_acc),
    .out_delta_energy        (res_de),
    .out_energy_total        (res_energy),
    .out_magnetization_total (res_mag)
  );

  // Spin lattice, one row per word.
  isingmp_ram #(
    .WIDTH (SIDE),
    .DEPTH (SIDE)
  ) u_lattice (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // Pack the result, pad to whole bytes.
  assign out_tdata = {{(isingmp_pkg::OUT_TDATA_W - isingmp_pkg::OUT_PAYLOAD_W){1'b0}},
                      res_mag, res_energy, res_de, res_acc};

endmodule
